// ===== hw/rtl/cpu16_pkg.sv =====
package cpu16_pkg;

    localparam int MEM_WORDS_DEF = 65536;
    localparam int NUM_REGS_DEF  = 8;
    localparam int WORD_W        = 16;
    localparam logic [15:0] SP_RESET = 16'hFFFC;

    // Input item kinds.
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_EXEC  = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    // Opcodes.
    localparam logic [4:0] OP_IMOV  = 5'h00;
    localparam logic [4:0] OP_MOV   = 5'h01;
    localparam logic [4:0] OP_LOAD  = 5'h02;
    localparam logic [4:0] OP_STORE = 5'h03;
    localparam logic [4:0] OP_ADD   = 5'h04;
    localparam logic [4:0] OP_SUB   = 5'h05;
    localparam logic [4:0] OP_MUL   = 5'h06;
    localparam logic [4:0] OP_DIV   = 5'h07;
    localparam logic [4:0] OP_AND   = 5'h08;
    localparam logic [4:0] OP_OR    = 5'h09;
    localparam logic [4:0] OP_XOR   = 5'h0A;
    localparam logic [4:0] OP_NOT   = 5'h0B;
    localparam logic [4:0] OP_JMP   = 5'h0C;
    localparam logic [4:0] OP_JZ    = 5'h0D;
    localparam logic [4:0] OP_JNZ   = 5'h0E;
    localparam logic [4:0] OP_PUSH  = 5'h0F;
    localparam logic [4:0] OP_POP   = 5'h10;
    localparam logic [4:0] OP_CMP   = 5'h11;
    localparam logic [4:0] OP_HALT  = 5'h1F;

    // Divider handshake.
    typedef struct packed {
        logic        start;
        logic [15:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

endpackage

// ===== hw/rtl/cpu16_mem.sv =====
module cpu16_mem
    import cpu16_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF,
    localparam int AW = $clog2(MEM_WORDS)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);

    logic [15:0] mem [MEM_WORDS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/cpu16_div.sv =====
module cpu16_div
    import cpu16_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    // Restoring divider, one quotient bit per cycle.
    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [15:0] rem_reg;
    logic [15:0] quo_reg;
    logic [15:0] dsr_reg;
    logic        done_reg;
    logic [16:0] trial;

    assign trial = {rem_reg, quo_reg[15]} - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd16;
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dsr_reg  <= req.divisor;
            end else if (busy_reg) begin
                if (trial[16]) begin
                    rem_reg <= {rem_reg[14:0], quo_reg[15]};
                    quo_reg <= {quo_reg[14:0], 1'b0};
                end else begin
                    rem_reg <= trial[15:0];
                    quo_reg <= {quo_reg[14:0], 1'b1};
                end
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // A zero divisor leaves all quotient bits set, which is the wanted 0xFFFF.
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hw/rtl/cpu16_instruction_step_unit.sv =====
// cpu16 instruction step unit.
// Each transaction on the s_ channel carries func, address and data; the unit
// answers with exactly one transaction on the m_ channel carrying read_data,
// program_counter, halted and zero_flag.
// func 0 writes a memory word, 1 executes one instruction at the program
// counter, 2 restarts the program counter at zero, 3 reads a memory word.
// Items are handled one at a time; s_tready is low from acceptance until the
// result has been taken. Memory writes and restart go from fetch straight to
// the result; reads pass fetch, decode and result; plain instructions pass
// fetch, decode, execute and result; LOAD and POP add a memory step because
// the single memory read port is used a second time; DIV adds a divider step
// in which the divider is loaded once and then resolves one quotient bit per
// cycle. s_tready comes back when the state returns to idle at the edge at
// which the result is taken, so a new item is accepted only after that.
// The result register holds its value while m_tready is low, and the unit
// accepts nothing new until it is taken.
// Reset (aresetn low, synchronous) clears the registers, program counter and
// flag, sets the stack pointer to 0xFFFC; memory content is not cleared and is
// undefined until written. No clearing pass is needed after reset.
module cpu16_instruction_step_unit
    import cpu16_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF,
    parameter int NUM_REGS  = NUM_REGS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // func[1:0], address[17:2], data[33:18], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // read_data[15:0], program_counter[31:16],
                                   // halted[32], zero_flag[33], zeros
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam int RW = $clog2(NUM_REGS);

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_DECODE, ST_EXEC, ST_MEM, ST_DIV, ST_OUT
    } state_t;

    state_t      state_reg;
    logic [1:0]  func_reg;
    logic [15:0] addr_reg;
    logic [15:0] data_reg;
    logic [15:0] regs_reg [NUM_REGS];
    logic [15:0] pc_reg;
    logic [15:0] sp_reg;
    logic        flag_reg;
    logic [15:0] insn_reg;
    logic [15:0] rd_reg;
    logic        halt_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [15:0]   mem_rdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [4:0]    op;
    logic [RW-1:0] ra, rb, rc;
    logic [15:0]   va, vb, vc;
    logic [15:0]   sp_inc;
    logic [31:0]   prod;
    logic [15:0]   join_ab;
    logic [15:0]   join_bc;

    assign op = insn_reg[15:11];
    assign ra = insn_reg[8 +: RW];
    assign rb = insn_reg[5 +: RW];
    assign rc = insn_reg[2 +: RW];
    assign va = regs_reg[ra];
    assign vb = regs_reg[rb];
    assign vc = regs_reg[rc];
    assign sp_inc = sp_reg + 16'd1;
    assign prod = va * vb;
    // Composed addresses: the high register shifted up by eight, or-ed with
    // the whole low register, kept to 16 bits.
    assign join_ab = {va[7:0], 8'd0} | vb;
    assign join_bc = {vb[7:0], 8'd0} | vc;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg[AW-1:0];
        mem_wdata = data_reg;
        mem_raddr = addr_reg[AW-1:0];
        case (state_reg)
            ST_IDLE: begin
                mem_we = 1'b0;
            end
            ST_FETCH: begin
                mem_we    = (func_reg == FUNC_WRITE);
                mem_raddr = (func_reg == FUNC_EXEC) ? pc_reg[AW-1:0] : addr_reg[AW-1:0];
            end
            ST_EXEC: begin
                if (op == OP_STORE) begin
                    mem_we    = 1'b1;
                    mem_waddr = join_ab[AW-1:0];
                    mem_wdata = vc;
                end else if (op == OP_PUSH) begin
                    mem_we    = 1'b1;
                    mem_waddr = sp_reg[AW-1:0];
                    mem_wdata = va;
                end
                mem_raddr = (op == OP_POP) ? sp_inc[AW-1:0] : join_bc[AW-1:0];
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    cpu16_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign div_req.start    = (state_reg == ST_EXEC) && (op == OP_DIV);
    assign div_req.dividend = va;
    assign div_req.divisor  = vb;

    cpu16_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            sp_reg    <= SP_RESET;
            flag_reg  <= 1'b0;
            halt_reg  <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                regs_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        func_reg  <= s_tdata[1:0];
                        addr_reg  <= s_tdata[17:2];
                        data_reg  <= s_tdata[33:18];
                        rd_reg    <= '0;
                        halt_reg  <= 1'b0;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    case (func_reg)
                        FUNC_WRITE: state_reg <= ST_OUT;
                        FUNC_RESTART: begin
                            pc_reg    <= '0;
                            state_reg <= ST_OUT;
                        end
                        default: state_reg <= ST_DECODE;
                    endcase
                end
                ST_DECODE: begin
                    if (func_reg == FUNC_READ) begin
                        rd_reg    <= mem_rdata;
                        state_reg <= ST_OUT;
                    end else begin
                        insn_reg  <= mem_rdata;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    state_reg <= ST_OUT;
                    pc_reg    <= pc_reg + 16'd1;
                    case (op)
                        OP_HALT: begin
                            halt_reg <= 1'b1;
                            pc_reg   <= pc_reg;
                        end
                        OP_IMOV: regs_reg[ra] <= {8'd0, insn_reg[7:0]};
                        OP_MOV:  regs_reg[ra] <= vb;
                        OP_LOAD: state_reg <= ST_MEM;
                        OP_ADD:  regs_reg[ra] <= va + vb;
                        OP_SUB:  regs_reg[ra] <= va - vb;
                        OP_MUL:  regs_reg[ra] <= prod[15:0];
                        OP_DIV:  state_reg <= ST_DIV;
                        OP_AND:  regs_reg[ra] <= va & vb;
                        OP_OR:   regs_reg[ra] <= va | vb;
                        OP_XOR:  regs_reg[ra] <= va ^ vb;
                        OP_NOT:  regs_reg[ra] <= ~vb;
                        OP_JMP:  pc_reg <= join_ab;
                        OP_JZ:   if (flag_reg) pc_reg <= join_ab;
                        OP_JNZ:  if (!flag_reg) pc_reg <= join_ab;
                        OP_PUSH: sp_reg <= sp_reg - 16'd1;
                        OP_POP: begin
                            sp_reg    <= sp_inc;
                            state_reg <= ST_MEM;
                        end
                        OP_CMP:  flag_reg <= (va == vb);
                        default: state_reg <= ST_OUT;
                    endcase
                end
                ST_MEM: begin
                    // Read data is registered by the memory, so the word addressed in ST_EXEC is valid here.
                    regs_reg[ra] <= mem_rdata;
                    state_reg    <= ST_OUT;
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        regs_reg[ra] <= div_rsp.quotient;
                        state_reg    <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {6'd0, flag_reg, halt_reg, pc_reg, rd_reg};

endmodule
